// ----- sv/nested_page_table_manager_assert.svh -----
`ifndef NESTED_PAGE_TABLE_MANAGER_ASSERT_SVH
`define NESTED_PAGE_TABLE_MANAGER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define NPT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define NPT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/npt_pkg.sv -----
`timescale 1ns / 1ps

package npt_pkg;

    // Fixed geometry of the translation tables
    localparam int ENTRIES_PER_TABLE = 512;
    localparam int IDX_W             = 9;
    localparam int PAGE_OFF_W        = 12;
    localparam int GA_W              = 57;
    localparam int HA_W              = 52;

    // Table entry: perm [2:0], memory type [5:3], frame [45:6]
    localparam int ENT_W      = 46;
    localparam int FRAME_LSB  = 6;
    localparam int FRAME_W    = 40;
    // Stored word carries one extra bit: written while the page was live
    localparam int MEM_W      = ENT_W + 1;
    localparam int STAMP_BIT  = ENT_W;

    localparam logic [2:0] MT_WB    = 3'd6;
    localparam logic [2:0] MT_NONE  = 3'd0;
    localparam logic [2:0] PERM_ALL = 3'b111;
    localparam logic [2:0] PERM_X   = 3'b100;

    typedef enum logic [1:0] {
        OP_MAP       = 2'd0,
        OP_PROTECT   = 2'd1,
        OP_UNMAP     = 2'd2,
        OP_TRANSLATE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK            = 2'd0,
        ST_NOT_FOUND     = 2'd1,
        ST_OUT_OF_TABLES = 2'd2
    } status_t;

    // Sequencer status seen by the top level
    typedef struct packed {
        logic busy;
        logic clearing;
        logic walking;
    } npt_stat_t;

endpackage

// ----- sv/nested_page_table_manager.sv -----
`timescale 1ns / 1ps

// Channel   | Handshake              | Payload
// ----------+------------------------+-----------------------------------------------
// request   | start && !busy         | op, guest_addr, host_addr, allow_read/write/exec
// result    | done (one-cycle pulse) | result_addr, status
// config    | cfg_we                 | cfg_wdata (walk_levels)
//
// A request walks each table level through the single RAM port in a read state and
// then a check state with an optional write: done pulses after the leaf check with four
// levels or five, sooner when a walk stops on a missing level or an out-of-pool frame.
// busy falls in the cycle done is shown, so the next request may be taken then.
// After reset a clearing pass writes every store entry with busy high; config writes
// are taken throughout. The result receiver cannot stall; done is high for one cycle
// only, while result_addr and status hold until the next result is shown.

`include "nested_page_table_manager_assert.svh"

module nested_page_table_manager import npt_pkg::*; #(
    parameter int TABLE_PAGES = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  logic [1:0]      op,
    input  logic [GA_W-1:0] guest_addr,
    input  logic [HA_W-1:0] host_addr,
    input  logic            allow_read,
    input  logic            allow_write,
    input  logic            allow_exec,
    input  logic            cfg_we,
    input  logic [2:0]      cfg_wdata,
    output logic            done,
    output logic [HA_W-1:0] result_addr,
    output logic [1:0]      status
);

    localparam int PW    = $clog2(TABLE_PAGES);
    localparam int AW    = PW + IDX_W;
    localparam int DEPTH = TABLE_PAGES * ENTRIES_PER_TABLE;

    logic [2:0]       walk_levels_reg;
    logic             mem_we;
    logic [AW-1:0]    mem_addr;
    logic [MEM_W-1:0] mem_wdata;
    logic [MEM_W-1:0] mem_rdata;
    npt_stat_t        stat;

    // Level-count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_levels_reg <= 3'd4;
        end
        else if (cfg_we)
        begin
            walk_levels_reg <= cfg_wdata;
        end
    end

    // Walk sequencer
    npt_seq #(
        .TABLE_PAGES (TABLE_PAGES)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .op          (op),
        .guest_addr  (guest_addr),
        .host_addr   (host_addr),
        .allow_read  (allow_read),
        .allow_write (allow_write),
        .allow_exec  (allow_exec),
        .walk_levels (walk_levels_reg),
        .done        (done),
        .result_addr (result_addr),
        .status      (status),
        .mem_we      (mem_we),
        .mem_addr    (mem_addr),
        .mem_wdata   (mem_wdata),
        .mem_rdata   (mem_rdata),
        .stat        (stat)
    );

    // Table page pool
    npt_ram #(
        .WIDTH (MEM_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    assign busy = stat.busy;

    // Checks
    `NPT_ASSERT_NXT(a_done_single, done, !done, "result strobe held for more than one cycle")
    `NPT_ASSERT_NXT(a_accept_busy, start && !busy, busy && stat.walking, "request taken without walk")
    `NPT_ASSERT_NOW(a_done_idle, done, !busy && !stat.walking, "result shown while still walking")
    `NPT_ASSERT_NOW(a_fail_zero, done && (status != ST_OK), result_addr == '0, "failed request with address")
    `NPT_ASSERT_NOW(a_clear_busy, stat.clearing, busy, "clearing pass while not busy")

endmodule

// ----- sv/npt_ram.sv -----
`timescale 1ns / 1ps

module npt_ram #(
    parameter int WIDTH = 47,
    parameter int DEPTH = 32768,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single port, read-first, registered read data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ----- sv/npt_seq.sv -----
`timescale 1ns / 1ps

module npt_seq import npt_pkg::*; #(
    parameter int TABLE_PAGES = 64,
    localparam int PW    = $clog2(TABLE_PAGES),
    localparam int NFW   = $clog2(TABLE_PAGES + 1),
    localparam int AW    = PW + IDX_W,
    localparam int DEPTH = TABLE_PAGES * ENTRIES_PER_TABLE
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [1:0]       op,
    input  logic [GA_W-1:0]  guest_addr,
    input  logic [HA_W-1:0]  host_addr,
    input  logic             allow_read,
    input  logic             allow_write,
    input  logic             allow_exec,
    input  logic [2:0]       walk_levels,
    output logic             done,
    output logic [HA_W-1:0]  result_addr,
    output logic [1:0]       status,
    output logic             mem_we,
    output logic [AW-1:0]    mem_addr,
    output logic [MEM_W-1:0] mem_wdata,
    input  logic [MEM_W-1:0] mem_rdata,
    output npt_stat_t        stat
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_RD,
        S_CHK
    } state_t;

    state_t            state_reg, state_next;
    logic [AW-1:0]     clr_cnt_reg, clr_cnt_next;
    op_t               op_reg, op_next;
    logic [GA_W-1:0]   ga_reg, ga_next;
    logic [HA_W-1:0]   ha_reg, ha_next;
    logic [2:0]        perm_reg, perm_next;
    logic [2:0]        lvl_reg, lvl_next;
    logic [PW-1:0]     cur_reg, cur_next;
    logic [NFW-1:0]    nf_reg, nf_next;
    logic              done_reg, done_next;
    logic [HA_W-1:0]   res_reg, res_next;
    status_t           status_reg, status_next;

    logic [AW-1:0]     slot;
    logic              page_live;
    logic [ENT_W-1:0]  ent;
    logic [FRAME_W-1:0] frame;

    // 9-bit index slice of the guest address for one level
    function automatic logic [IDX_W-1:0] level_index(input logic [GA_W-1:0] ga,
                                                     input logic [2:0] lvl);
        logic [IDX_W-1:0] idx;
        case (lvl)
            3'd1:    idx = ga[20:12];
            3'd2:    idx = ga[29:21];
            3'd3:    idx = ga[38:30];
            3'd4:    idx = ga[47:39];
            3'd5:    idx = ga[56:48];
            default: idx = '0;
        endcase
        return idx;
    endfunction

    assign slot      = {cur_reg, level_index(ga_reg, lvl_reg)};
    assign page_live = NFW'(cur_reg) < nf_reg;
    // Entries left from before the page was allocated read as zero
    assign ent       = (page_live && !mem_rdata[STAMP_BIT]) ? '0 : mem_rdata[ENT_W-1:0];
    assign frame     = ent[ENT_W-1:FRAME_LSB];

    // Next-state and memory port
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        op_next      = op_reg;
        ga_next      = ga_reg;
        ha_next      = ha_reg;
        perm_next    = perm_reg;
        lvl_next     = lvl_reg;
        cur_next     = cur_reg;
        nf_next      = nf_reg;
        done_next    = 1'b0;
        res_next     = res_reg;
        status_next  = status_reg;
        mem_we       = 1'b0;
        mem_addr     = slot;
        mem_wdata    = {page_live, {ENT_W{1'b0}}};

        case (state_reg)
            // Sweep the whole store to zero after reset
            S_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_addr     = clr_cnt_reg;
                mem_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    op_next    = op_t'(op);
                    ga_next    = guest_addr;
                    ha_next    = host_addr;
                    perm_next  = {allow_exec, allow_write, allow_read};
                    lvl_next   = (walk_levels == 3'd5) ? 3'd5 : 3'd4;
                    cur_next   = '0;
                    state_next = S_RD;
                end
            end

            // Address is on the port, data comes back next cycle
            S_RD:
            begin
                state_next = S_CHK;
            end

            S_CHK:
            begin
                if (lvl_reg != 3'd1)
                begin
                    // Intermediate level
                    if (!ent[0])
                    begin
                        if (op_reg != OP_MAP)
                        begin
                            status_next = ST_NOT_FOUND;
                            res_next    = '0;
                            done_next   = 1'b1;
                            state_next  = S_IDLE;
                        end
                        else if (nf_reg >= NFW'(TABLE_PAGES))
                        begin
                            status_next = ST_OUT_OF_TABLES;
                            res_next    = '0;
                            done_next   = 1'b1;
                            state_next  = S_IDLE;
                        end
                        else
                        begin
                            // Link a fresh page and descend into it; a page that
                            // links itself goes live with this write
                            mem_we     = 1'b1;
                            mem_wdata  = {page_live || (NFW'(cur_reg) == nf_reg),
                                          FRAME_W'(nf_reg), MT_NONE, PERM_ALL};
                            cur_next   = nf_reg[PW-1:0];
                            nf_next    = nf_reg + NFW'(1);
                            lvl_next   = lvl_reg - 3'd1;
                            state_next = S_RD;
                        end
                    end
                    else if (frame >= FRAME_W'(TABLE_PAGES))
                    begin
                        // Dangling intermediate frame
                        status_next = ST_NOT_FOUND;
                        res_next    = '0;
                        done_next   = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        cur_next   = frame[PW-1:0];
                        lvl_next   = lvl_reg - 3'd1;
                        state_next = S_RD;
                    end
                end
                else
                begin
                    // Leaf
                    status_next = ST_OK;
                    res_next    = '0;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                    case (op_reg)
                        OP_MAP:
                        begin
                            mem_we    = 1'b1;
                            mem_wdata = {page_live, ha_reg[HA_W-1:PAGE_OFF_W], MT_WB,
                                         perm_reg};
                        end
                        OP_PROTECT:
                        begin
                            mem_we    = 1'b1;
                            mem_wdata = {page_live, ent[ENT_W-1:3], perm_reg};
                        end
                        OP_UNMAP:
                        begin
                            mem_we    = 1'b1;
                            mem_wdata = {page_live, {FRAME_W{1'b0}}, ent[5:3], PERM_X};
                            res_next  = {frame, {PAGE_OFF_W{1'b0}}};
                        end
                        OP_TRANSLATE:
                        begin
                            res_next  = {frame, ga_reg[PAGE_OFF_W-1:0]};
                        end
                        default:
                        begin
                            res_next  = '0;
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            op_reg      <= OP_MAP;
            ga_reg      <= '0;
            ha_reg      <= '0;
            perm_reg    <= '0;
            lvl_reg     <= 3'd4;
            cur_reg     <= '0;
            nf_reg      <= NFW'(1);
            done_reg    <= 1'b0;
            res_reg     <= '0;
            status_reg  <= ST_OK;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            op_reg      <= op_next;
            ga_reg      <= ga_next;
            ha_reg      <= ha_next;
            perm_reg    <= perm_next;
            lvl_reg     <= lvl_next;
            cur_reg     <= cur_next;
            nf_reg      <= nf_next;
            done_reg    <= done_next;
            res_reg     <= res_next;
            status_reg  <= status_next;
        end
    end

    assign done          = done_reg;
    assign result_addr   = res_reg;
    assign status        = status_reg;
    assign stat.busy     = (state_reg != S_IDLE);
    assign stat.clearing = (state_reg == S_CLEAR);
    assign stat.walking  = (state_reg == S_RD) || (state_reg == S_CHK);

endmodule

// ----- tb/nested_page_table_manager_checker.sv -----
`timescale 1ns / 1ps

module nested_page_table_manager_checker import npt_pkg::*; #(
    parameter int TABLE_PAGES = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic            busy,
    input  logic [1:0]      op,
    input  logic [GA_W-1:0] guest_addr,
    input  logic [HA_W-1:0] host_addr,
    input  logic            allow_read,
    input  logic            allow_write,
    input  logic            allow_exec,
    input  logic            cfg_we,
    input  logic [2:0]      cfg_wdata,
    input  logic            done,
    input  logic [HA_W-1:0] result_addr,
    input  logic [1:0]      status,
    output int              mismatches,
    output int              outstanding
);

    typedef struct packed {
        logic [HA_W-1:0] addr;
        status_t         st;
    } outcome_t;

    // Shadow copy of the table pool, allocator and level setting
    logic [ENT_W-1:0] shadow_store [TABLE_PAGES*ENTRIES_PER_TABLE];
    int unsigned      alloc_next;
    logic [2:0]       levels_reg;
    outcome_t         awaited [$];
    outcome_t         want_res;

    // 9-bit table index for one level, level 1 being the leaf table
    function automatic logic [IDX_W-1:0] slice(logic [GA_W-1:0] ga, int lvl);
        return ga[IDX_W*(lvl-1)+PAGE_OFF_W +: IDX_W];
    endfunction

    // Walk the shadow tables for one request, update them, return the outcome
    function automatic outcome_t walk_request(op_t code, logic [GA_W-1:0] ga,
                                              logic [HA_W-1:0] ha, logic [2:0] perm);
        outcome_t         res;
        int               depth;
        int               lvl;
        int               k;
        int unsigned      page;
        int unsigned      p;
        int unsigned      slot;
        logic [ENT_W-1:0] e;
        logic [FRAME_W-1:0] f;

        res.addr = '0;
        res.st   = ST_OK;
        depth    = (levels_reg == 3'd5) ? 5 : 4;
        page     = 0;
        for (lvl = depth; lvl >= 2; lvl--)
        begin
            slot = page * ENTRIES_PER_TABLE + slice(ga, lvl);
            e    = shadow_store[slot];
            if (!e[0])
            begin
                // missing level: only map builds it, if the pool has room
                if (code != OP_MAP)
                begin
                    res.st = ST_NOT_FOUND;
                    return res;
                end
                if (alloc_next >= TABLE_PAGES)
                begin
                    res.st = ST_OUT_OF_TABLES;
                    return res;
                end
                p = alloc_next;
                alloc_next++;
                for (k = 0; k < ENTRIES_PER_TABLE; k++)
                    shadow_store[p*ENTRIES_PER_TABLE + k] = '0;
                shadow_store[slot] = {FRAME_W'(p), MT_NONE, PERM_ALL};
                page = p;
            end
            else
            begin
                // a frame outside the pool ends the walk
                f = e[ENT_W-1:FRAME_LSB];
                if (f >= TABLE_PAGES)
                begin
                    res.st = ST_NOT_FOUND;
                    return res;
                end
                page = 32'(f);
            end
        end

        slot = page * ENTRIES_PER_TABLE + slice(ga, 1);
        e    = shadow_store[slot];
        case (code)
            OP_MAP:
                shadow_store[slot] = {ha[HA_W-1:PAGE_OFF_W], MT_WB, perm};
            OP_PROTECT:
                shadow_store[slot] = {e[ENT_W-1:3], perm};
            OP_UNMAP:
            begin
                res.addr = {e[ENT_W-1:FRAME_LSB], {PAGE_OFF_W{1'b0}}};
                shadow_store[slot] = {{FRAME_W{1'b0}}, e[5:3], PERM_X};
            end
            default:
                res.addr = {e[ENT_W-1:FRAME_LSB], ga[PAGE_OFF_W-1:0]};
        endcase
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH at %0t: %s: got %h, expected %h", $time, what, got, want);
        mismatches++;
    endtask

    // Compare each result with the oldest prediction, then record new requests
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < TABLE_PAGES*ENTRIES_PER_TABLE; k++)
                shadow_store[k] = '0;
            alloc_next  = 1;
            levels_reg  = 3'd4;
            mismatches  = 0;
            awaited.delete();
            outstanding <= 0;
        end
        else
        begin
            if (done)
            begin
                if (awaited.size() == 0)
                    report_mismatch("result with no request outstanding",
                                    64'(result_addr), 64'(status));
                else
                begin
                    want_res = awaited.pop_front();
                    if (result_addr !== want_res.addr)
                        report_mismatch("result_addr", 64'(result_addr), 64'(want_res.addr));
                    if (status !== want_res.st)
                        report_mismatch("status", 64'(status), 64'(want_res.st));
                end
            end
            if (cfg_we)
                levels_reg = cfg_wdata;
            if (start && !busy)
                awaited.push_back(walk_request(op_t'(op), guest_addr, host_addr,
                                               {allow_exec, allow_write, allow_read}));
            outstanding <= awaited.size();
        end
    end

endmodule

// ----- tb/nested_page_table_manager_test.sv -----
`timescale 1ns / 1ps

module nested_page_table_manager_test;
    import npt_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 160;

    logic            clk;
    logic            rst_n;
    logic            start;
    logic            busy;
    logic [1:0]      op;
    logic [GA_W-1:0] guest_addr;
    logic [HA_W-1:0] host_addr;
    logic            allow_read;
    logic            allow_write;
    logic            allow_exec;
    logic            cfg_we;
    logic [2:0]      cfg_wdata;
    logic            done;
    logic [HA_W-1:0] result_addr;
    logic [1:0]      status;
    int              mismatches;
    int              outstanding;
    int              cycles = 0;

    // Upper index slices of the address regions used by random requests
    logic [IDX_W-1:0] hi5 [8];
    logic [IDX_W-1:0] hi4 [8];
    logic [IDX_W-1:0] hi3 [8];

    nested_page_table_manager DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .op          (op),
        .guest_addr  (guest_addr),
        .host_addr   (host_addr),
        .allow_read  (allow_read),
        .allow_write (allow_write),
        .allow_exec  (allow_exec),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .done        (done),
        .result_addr (result_addr),
        .status      (status)
    );

    nested_page_table_manager_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .op          (op),
        .guest_addr  (guest_addr),
        .host_addr   (host_addr),
        .allow_read  (allow_read),
        .allow_write (allow_write),
        .allow_exec  (allow_exec),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .done        (done),
        .result_addr (result_addr),
        .status      (status),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Present a request and hold it until the block takes it
    task automatic issue(op_t code, logic [GA_W-1:0] ga, logic [HA_W-1:0] ha,
                         logic [2:0] perm);
        start      <= 1'b1;
        op         <= code;
        guest_addr <= ga;
        host_addr  <= ha;
        {allow_exec, allow_write, allow_read} <= perm;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic pause(int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Wait for every result, then a margin beyond the longest walk
    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (16) @(posedge clk);
    endtask

    task automatic set_levels(logic [2:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [2:0] phase_setting(int n);
        case (n)
            0:       return 3'd4;
            1:       return 3'd0;
            2:       return 3'd7;
            3:       return 3'd5;
            4:       return 3'd6;
            5:       return 3'd4;
            6:       return 3'd3;
            default: return 3'd5;
        endcase
    endfunction

    // Mostly addresses inside a few regions so walks reuse tables; some noise
    task automatic random_request();
        logic [GA_W-1:0] ga;
        logic [HA_W-1:0] ha;
        int              r;
        int              pick;
        op_t             code;

        r = $urandom_range(0, 7);
        if ($urandom_range(0, 9) == 0)
            ga = GA_W'({$urandom, $urandom});
        else
            ga = {hi5[r], hi4[r], hi3[r], 9'($urandom_range(0, 3)),
                  ($urandom_range(0, 3) == 0) ? 9'($urandom) : 9'($urandom_range(0, 15)),
                  12'($urandom)};
        // small frames make leaves that read as valid pool pages on a deeper walk
        if ($urandom_range(0, 1) == 1)
            ha = HA_W'({$urandom, $urandom});
        else
            ha = {40'($urandom_range(0, 63)), 12'($urandom)};
        pick = $urandom_range(0, 99);
        code = (pick < 30) ? OP_MAP :
               (pick < 50) ? OP_PROTECT :
               (pick < 65) ? OP_UNMAP : OP_TRANSLATE;
        issue(code, ga, ha, 3'($urandom));
    endtask

    initial
    begin
        int ph;
        int n;
        bit quiet;

        clk         = 1'b0;
        rst_n       = 1'b0;
        start       = 1'b0;
        op          = '0;
        guest_addr  = '0;
        host_addr   = '0;
        allow_read  = 1'b0;
        allow_write = 1'b0;
        allow_exec  = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;

        // Regions 4..7 shift regions 0..3 up one level, so a five-level walk
        // lands on tables built by four-level walks
        for (n = 0; n < 4; n++)
        begin
            hi5[n] = (n < 2) ? '0 : 9'($urandom);
            hi4[n] = 9'($urandom);
            hi3[n] = 9'($urandom);
        end
        for (n = 4; n < 8; n++)
        begin
            hi5[n] = hi4[n-4];
            hi4[n] = hi3[n-4];
            hi3[n] = 9'($urandom_range(0, 3));
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        set_levels(3'd4);

        // Directed: empty tables, extremes, each operation, ignored top bits
        issue(OP_TRANSLATE, '0, '0, 3'b111);
        issue(OP_PROTECT, '0, '0, 3'b111);
        issue(OP_UNMAP, '0, '0, 3'b000);
        issue(OP_MAP, '0, '1, 3'b111);
        issue(OP_TRANSLATE, 57'hFFF, '0, 3'b000);
        issue(OP_MAP, '1, '0, 3'b000);
        issue(OP_TRANSLATE, '1, '1, 3'b111);
        issue(OP_TRANSLATE, {9'h000, 48'hFFFF_FFFF_FFFF}, '0, 3'b000);
        issue(OP_PROTECT, '0, '1, 3'b010);
        issue(OP_TRANSLATE, 57'h123, '0, 3'b000);
        issue(OP_UNMAP, '0, '0, 3'b000);
        // unmap of an already cleared leaf still acts on it
        issue(OP_UNMAP, '0, '1, 3'b111);
        issue(OP_TRANSLATE, '0, '0, 3'b000);
        issue(OP_MAP, 57'h1000, 52'hBCDE_F0123_4567, 3'b101);
        issue(OP_MAP, 57'h2000, 52'h5ABC, 3'b011);

        // Five levels over four-level tables: out-of-pool frame, page reuse
        drain();
        set_levels(3'd5);
        issue(OP_TRANSLATE, 57'(1) << 21, '0, 3'b000);
        issue(OP_MAP, 57'(1) << 21, '1, 3'b111);
        issue(OP_TRANSLATE, (57'(2) << 21) | (57'h1FF << 12) | 57'hABC, '0, 3'b000);
        issue(OP_MAP, 57'(1) << 48, 52'h1_2345_6789_A000, 3'b110);
        issue(OP_TRANSLATE, '0, '0, 3'b000);

        // Random phases, one level setting each; one phase runs with no idling
        for (ph = 0; ph < PHASES; ph++)
        begin
            drain();
            set_levels(phase_setting(ph));
            quiet = (ph == 2);
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                random_request();
                if (!quiet && $urandom_range(0, 99) < 22)
                    pause($urandom_range(1, 12));
            end
        end

        drain();
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+sv
sv/npt_pkg.sv
sv/npt_ram.sv
sv/npt_seq.sv
sv/nested_page_table_manager.sv
tb/nested_page_table_manager_checker.sv
tb/nested_page_table_manager_test.sv
